// ===== hdl/rth_pkg.sv =====
// Package for the RGB to HSL converter: channel and angle constants,
// field widths, the hue sector code and the word carried through the divider stages.
// No dependencies.
`default_nettype none

package rth_pkg;

	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 9;
	localparam int PCT_W      = 7;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;

	localparam int CHAN_MAX   = 255;
	localparam int HUE_SECTOR = 60;
	localparam int HUE_GREEN  = 120;
	localparam int HUE_BLUE   = 240;
	localparam int HUE_FULL   = 360;
	localparam int PCT_FULL   = 100;
	localparam int PCT_HALF   = 50;

	// Both dividers produce a quotient of at most 100, so seven steps suffice.
	localparam int QUO_W  = 7;
	localparam int NUM_W  = 15;   // 100 * 255 fits
	localparam int HDEN_W = 8;    // max - min
	localparam int SDEN_W = 9;    // sum or 510 - sum
	localparam int LNUM_W = 16;   // 50 * 510 plus correction terms

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} hue_sect_t;

	typedef struct packed {
		logic               grey;
		logic               neg;
		hue_sect_t          sect;
		logic [PCT_W-1:0]   light;
		logic [NUM_W-1:0]   hrem;
		logic [HDEN_W-1:0]  hden;
		logic [QUO_W-1:0]   hq;
		logic [NUM_W-1:0]   srem;
		logic [SDEN_W-1:0]  sden;
		logic [QUO_W-1:0]   sq;
	} div_word_t;

endpackage

`default_nettype wire

// ===== hdl/rgb_to_hsl.sv =====
// Pipelined RGB to HSL converter, top level and only module.
// Depends on rth_pkg for constants, widths and the divider stage word.
`default_nettype none

// The block takes one 8-bit RGB pixel per word and returns integer hue in
// degrees (0 to 359) with saturation and lightness in whole percent (0 to 100).
// It accepts a new pixel in every clock cycle unless stalled, and each pixel
// moves stage by stage. The first stage finds the largest and smallest
// channel and picks the hue sector, with blue winning ties over green and green
// over red. The second stage forms the scaled numerators, the saturation
// denominator and the lightness, which divides by 255 through a reciprocal
// multiply. Seven stages of a restoring divider, one quotient bit per stage,
// run the hue and saturation divisions side by side, and the last stage adds
// the sector offset and wraps negative hues. Grey pixels give zero hue and zero
// saturation. Each stage holds its word while the stage after it is full and
// stalled, so bubbles are squeezed out and a stall at the output drops or
// repeats nothing; the input stays ready as long as any stage can move.
module rgb_to_hsl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// [7:0] red, [15:8] green, [23:16] blue
	input  wire logic [rth_pkg::IN_DATA_W-1:0] s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [8:0] hue, [15:9] saturation, [22:16] lightness, [23] zero
	output logic [rth_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import rth_pkg::*;

	localparam int NDIV = QUO_W;

	// Stage 1: extremes and hue sector.
	logic                v_s1;
	logic [CHAN_W-1:0]   mx_s1, mn_s1, adiff_s1;
	logic                neg_s1;
	hue_sect_t           sect_s1;

	// Stage 2: numerators, denominators and lightness.
	logic                v_s2;
	div_word_t           w_s2;

	// Divider stages.
	logic                dv_v_s [NDIV];
	div_word_t           dv_s   [NDIV];
	logic                dv_en  [NDIV];

	// Output stage.
	logic                v_s10;
	logic [HUE_W-1:0]    hue_s10;
	logic [PCT_W-1:0]    sat_s10, light_s10;

	logic en_s1, en_s2, en_s10;

	// A stage may load when it is empty or when its contents move on.
	assign en_s10 = !v_s10 || m_tready;
	always_comb begin
		dv_en[NDIV-1] = !dv_v_s[NDIV-1] || en_s10;
		for (int i = NDIV-2; i >= 0; i--) begin
			dv_en[i] = !dv_v_s[i] || dv_en[i+1];
		end
	end
	assign en_s2    = !v_s2 || dv_en[0];
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	// ---------------- Stage 1 ----------------
	logic [CHAN_W-1:0] red, green, blue;
	logic [CHAN_W-1:0] mx_c, mn_c, op_a, op_b;
	logic [CHAN_W:0]   diff_c;
	hue_sect_t         sect_c;

	assign red   = s_tdata[CHAN_W-1:0];
	assign green = s_tdata[2*CHAN_W-1:CHAN_W];
	assign blue  = s_tdata[3*CHAN_W-1:2*CHAN_W];

	always_comb begin
		mx_c = red;
		mn_c = red;
		if (green > mx_c) mx_c = green;
		if (blue > mx_c)  mx_c = blue;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c)  mn_c = blue;
		if (blue == mx_c) begin
			sect_c = SECT_BLUE;
			op_a   = red;
			op_b   = green;
		end else if (green == mx_c) begin
			sect_c = SECT_GREEN;
			op_a   = blue;
			op_b   = red;
		end else begin
			sect_c = SECT_RED;
			op_a   = green;
			op_b   = blue;
		end
		diff_c = {1'b0, op_a} - {1'b0, op_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mx_s1    <= mx_c;
			mn_s1    <= mn_c;
			sect_s1  <= sect_c;
			neg_s1   <= diff_c[CHAN_W];
			adiff_s1 <= diff_c[CHAN_W] ? CHAN_W'(-diff_c) : diff_c[CHAN_W-1:0];
		end
	end

	// ---------------- Stage 2 ----------------
	logic [HDEN_W-1:0] d_c;
	logic [SDEN_W-1:0] sum_c, sden_c;
	logic [LNUM_W-1:0] lnum_c, lq_c;
	logic              grey_c;
	div_word_t         w2_c;

	always_comb begin
		d_c    = mx_s1 - mn_s1;
		sum_c  = {1'b0, mx_s1} + {1'b0, mn_s1};
		grey_c = (d_c == '0);
		// Lightness below 50 percent exactly when the sum is below 255.
		if (sum_c < SDEN_W'(CHAN_MAX)) begin
			sden_c = sum_c;
		end else begin
			sden_c = SDEN_W'(2*CHAN_MAX) - sum_c;
		end
		// floor(x / 255) = (x + 1 + (x >> 8)) >> 8 over this range.
		lnum_c = LNUM_W'(sum_c) * LNUM_W'(PCT_HALF);
		lq_c   = (lnum_c + LNUM_W'(1) + (lnum_c >> 8)) >> 8;

		w2_c       = '0;
		w2_c.grey  = grey_c;
		w2_c.neg   = neg_s1;
		w2_c.sect  = sect_s1;
		w2_c.light = lq_c[PCT_W-1:0];
		w2_c.hrem  = NUM_W'(adiff_s1) * NUM_W'(HUE_SECTOR);
		w2_c.srem  = NUM_W'(d_c) * NUM_W'(PCT_FULL);
		// A grey pixel's quotients are discarded; keep the divisors nonzero.
		w2_c.hden  = grey_c ? HDEN_W'(1) : d_c;
		w2_c.sden  = grey_c ? SDEN_W'(1) : sden_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			w_s2 <= w2_c;
		end
	end

	// ---------------- Divider stages ----------------
	for (genvar i = 0; i < NDIV; i++) begin : g_div
		localparam int BIT = NDIV - 1 - i;
		div_word_t        din, dout;
		logic             vin;
		logic [NUM_W-1:0] hsh, ssh;

		if (i == 0) begin : g_first
			assign din = w_s2;
			assign vin = v_s2;
		end else begin : g_next
			assign din = dv_s[i-1];
			assign vin = dv_v_s[i-1];
		end

		always_comb begin
			hsh  = NUM_W'(din.hden) << BIT;
			ssh  = NUM_W'(din.sden) << BIT;
			dout = din;
			if (din.hrem >= hsh) begin
				dout.hrem    = din.hrem - hsh;
				dout.hq[BIT] = 1'b1;
			end
			if (din.srem >= ssh) begin
				dout.srem    = din.srem - ssh;
				dout.sq[BIT] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[i] <= 1'b0;
			end else if (dv_en[i]) begin
				dv_v_s[i] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (dv_en[i]) begin
				dv_s[i] <= dout;
			end
		end
	end

	// ---------------- Output stage ----------------
	div_word_t        wl;
	logic [HUE_W-1:0] base_c, hue_c, q9;

	assign wl = dv_s[NDIV-1];
	assign q9 = HUE_W'(wl.hq);

	always_comb begin
		case (wl.sect)
			SECT_BLUE:  base_c = HUE_W'(HUE_BLUE);
			SECT_GREEN: base_c = HUE_W'(HUE_GREEN);
			default:    base_c = '0;
		endcase
		if (wl.grey) begin
			hue_c = '0;
		end else if (!wl.neg) begin
			hue_c = base_c + q9;
		end else if (wl.sect == SECT_RED) begin
			// Negative red-sector hue wraps around the circle.
			hue_c = (q9 == '0) ? '0 : HUE_W'(HUE_FULL) - q9;
		end else begin
			hue_c = base_c - q9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en_s10) begin
			v_s10 <= dv_v_s[NDIV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			hue_s10   <= hue_c;
			sat_s10   <= wl.grey ? '0 : wl.sq;
			light_s10 <= wl.light;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = {(OUT_DATA_W-HUE_W-2*PCT_W)'(0), light_s10, sat_s10, hue_s10};

endmodule

`default_nettype wire
